FILE: rtl/gqr_pkg.sv
// Shared types and constants for the Givens QR block.
// No dependencies.
package gqr_pkg;
  localparam int DEF_MAX_DIM = 4;
  localparam int DIM_W       = 3;
  localparam int DATA_W      = 32;
  localparam int IDX_W       = 2;
  localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

  typedef struct packed {
    logic                     which_matrix;
    logic [IDX_W-1:0]         out_row;
    logic [IDX_W-1:0]         out_col;
    logic signed [DATA_W-1:0] out_value;
    logic                     last_of_run;
  } result_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // round half up from 2^-30 units; floor shift after adding the half
  function automatic logic signed [63:0] rnd30(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = v + 64'sd536870912;
    return t >>> 30;
  endfunction
endpackage

FILE: rtl/gqr_if.sv
// Valid/ready channel interfaces for the Givens QR block.
// Depends on gqr_pkg.
interface gqr_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] elem_value;
  modport source (output valid, elem_value, input ready);
  modport sink   (input valid, elem_value, output ready);
endinterface

interface gqr_out_if;
  logic               valid;
  logic               ready;
  gqr_pkg::result_t   data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

FILE: rtl/givens_qr_decomposition.sv
// Givens QR decomposition: n*n elements in, Q then R out (2*n*n beats); depends on gqr_pkg, gqr_if.
// After the last element, each rotation runs a setup step, the bit-serial root steps, two
//   restoring divider runs, the update steps and an advance step (a skipped rotation: setup and advance);
//   then the first output beat is registered, and one beat follows per cycle while ready.
// Elements are accepted only in load; not ready during compute, output or a cfg write.
// Sync active-high reset: size 4, load count 0, idle. R store not cleared.
module givens_qr_decomposition #(
  parameter int MAX_DIM = gqr_pkg::DEF_MAX_DIM
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [gqr_pkg::DIM_W-1:0] cfg_data,
  gqr_in_if.sink                   in_ch,
  gqr_out_if.source                out_ch
);
  import gqr_pkg::*;

  localparam int CAP   = (MAX_DIM < 4) ? MAX_DIM : 4;
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = $clog2(MAX_DIM);

  localparam logic [2:0] S_LOAD = 3'd0, S_SETUP = 3'd1, S_SQRT = 3'd2,
                         S_DIV = 3'd3, S_UPD = 3'd4, S_NEXT = 3'd5, S_OUT = 3'd6;

  logic [2:0] state;
  logic [DIM_W-1:0] size_in_use;
  logic [4:0] load_count;
  logic signed [31:0] r_store [DEPTH];
  logic signed [31:0] q_store [DEPTH];

  logic [2:0] n;
  always_comb begin
    n = size_in_use;
    if (n < 3'd2) n = 3'd2;
    if (n > 3'(CAP)) n = 3'(CAP);
  end
  logic [4:0] nn;
  assign nn = 5'(n * n);

  logic [RW-1:0] ld_row, ld_col;
  logic [RW-1:0] ci, cj, ck;
  logic [5:0] step;
  // root (bit-serial), divider (restoring)
  logic [63:0] sq_x, sq_res, sq_bit;
  logic [63:0] dv_rem, dv_den;
  logic [62:0] dv_num;
  logic        dv_neg, dv_sel;
  logic signed [31:0] c_r, s_r;
  logic signed [31:0] pv, tv;
  logic [1:0] phase;
  logic signed [31:0] ua, ub;
  logic signed [63:0] pa, pb;
  logic last_beat;

  function automatic logic [AW-1:0] ad(input logic [RW-1:0] r, input logic [RW-1:0] c);
    return AW'(r * MAX_DIM + c);
  endfunction

  assign in_ch.ready = (state == S_LOAD) && !cfg_we;
  wire in_acc = in_ch.valid && in_ch.ready;

  // one multiplier pair, fed by phase
  always_comb begin
    ua = (phase[0]) ? ((phase[1]) ? q_store[ad(ci, ck)] : r_store[ad(ci, ck)])
                    : ((phase[1]) ? q_store[ad(cj, ck)] : r_store[ad(cj, ck)]);
    ub = (phase[0]) ? ((phase[1]) ? q_store[ad(cj, ck)] : r_store[ad(cj, ck)])
                    : ((phase[1]) ? q_store[ad(ci, ck)] : r_store[ad(ci, ck)]);
  end

  logic signed [31:0] tmp_j;
  logic signed [63:0] t_abs;
  logic [63:0] trial;
  logic        q_bit;
  logic signed [64:0] q_emit;

  assign trial  = {dv_rem[62:0], dv_num[62]};
  assign q_bit  = (trial >= dv_den);
  assign t_abs  = 64'({dv_num[61:0], q_bit});
  assign pa     = 64'(c_r) * 64'(ua);
  assign pb     = 64'(s_r) * 64'(ub);
  assign q_emit = 65'(rnd30(64'(q_store[ad(cj, ci)]) <<< 16));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      size_in_use <= 3'd4;
      load_count <= '0;
      ld_row <= '0;
      ld_col <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        size_in_use <= cfg_data;
        load_count <= '0;
        ld_row <= '0;
        ld_col <= '0;
      end
      case (state)
        S_LOAD: if (in_acc) begin
          r_store[ad(ld_row, ld_col)] <= in_ch.elem_value;
          if (load_count + 5'd1 >= nn) begin
            load_count <= '0;
            ld_row <= '0;
            ld_col <= '0;
            for (int a = 0; a < MAX_DIM; a++)
              for (int b = 0; b < MAX_DIM; b++)
                q_store[AW'(a * MAX_DIM + b)] <= (a == b) ? ONE_Q30 : 32'sd0;
            cj <= '0;
            ci <= RW'(1);
            state <= S_SETUP;
          end else begin
            load_count <= load_count + 5'd1;
            if (3'(ld_col) + 3'd1 >= n) begin
              ld_col <= '0;
              ld_row <= ld_row + RW'(1);
            end else begin
              ld_col <= ld_col + RW'(1);
            end
          end
        end
        S_SETUP: begin
          pv <= r_store[ad(cj, cj)];
          tv <= r_store[ad(ci, cj)];
          if (r_store[ad(ci, cj)] == 32'sd0) begin
            state <= S_NEXT;
          end else begin
            sq_x <= 64'($signed(r_store[ad(cj, cj)]) * $signed(r_store[ad(cj, cj)]))
                  + 64'($signed(r_store[ad(ci, cj)]) * $signed(r_store[ad(ci, cj)]));
            sq_res <= '0;
            sq_bit <= 64'h4000_0000_0000_0000;
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sq_bit == 64'd0) begin
            dv_sel <= 1'b0;
            dv_den <= sq_res;
            dv_neg <= pv[31];
            dv_num <= 63'({32'(pv[31] ? -33'(pv) : 33'(pv)), 30'd0});
            dv_rem <= '0;
            step <= '0;
            state <= S_DIV;
          end else begin
            if (sq_x >= sq_res + sq_bit) begin
              sq_x <= sq_x - (sq_res + sq_bit);
              sq_res <= (sq_res >> 1) + sq_bit;
            end else begin
              sq_res <= sq_res >> 1;
            end
            sq_bit <= sq_bit >> 2;
          end
        end
        S_DIV: begin
          if (step == 6'd62) begin
            if (!dv_sel) begin
              c_r <= dv_neg ? -32'(t_abs) : 32'(t_abs);
              dv_sel <= 1'b1;
              dv_neg <= tv[31];
              dv_num <= 63'({32'(tv[31] ? -33'(tv) : 33'(tv)), 30'd0});
              dv_rem <= '0;
              step <= '0;
            end else begin
              s_r <= dv_neg ? -32'(t_abs) : 32'(t_abs);
              ck <= '0;
              phase <= '0;
              state <= S_UPD;
            end
          end else begin
            dv_num <= {dv_num[61:0], q_bit};
            dv_rem <= q_bit ? trial - dv_den : trial;
            step <= step + 6'd1;
          end
        end
        S_UPD: begin
          // phase 0: R row j, 1: R row i, 2: Q row j, 3: Q row i
          case (phase)
            2'd0: tmp_j <= sat32(rnd30(pa + pb));
            2'd1: begin
              r_store[ad(ci, ck)] <= sat32(rnd30(pa - pb));
              r_store[ad(cj, ck)] <= tmp_j;
            end
            2'd2: tmp_j <= sat32(rnd30(pa + pb));
            default: begin
              q_store[ad(ci, ck)] <= sat32(rnd30(pa - pb));
              q_store[ad(cj, ck)] <= tmp_j;
            end
          endcase
          phase <= phase + 2'd1;
          if (phase == 2'd3) begin
            if (3'(ck) + 3'd1 >= n) state <= S_NEXT;
            else ck <= ck + RW'(1);
          end
        end
        S_NEXT: begin
          if (3'(ci) + 3'd1 < n) begin
            ci <= ci + RW'(1);
            state <= S_SETUP;
          end else if (3'(cj) + 3'd2 < n) begin
            cj <= cj + RW'(1);
            ci <= cj + RW'(2);
            state <= S_SETUP;
          end else begin
            ci <= '0;
            cj <= '0;
            dv_sel <= 1'b0;
            out_ch.valid <= 1'b0;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_ch.valid || out_ch.ready) begin
            if (out_ch.valid && last_beat) begin
              out_ch.valid <= 1'b0;
              state <= S_LOAD;
            end else begin
              out_ch.valid <= 1'b1;
              out_ch.data.which_matrix <= dv_sel;
              out_ch.data.out_row <= IDX_W'(ci);
              out_ch.data.out_col <= IDX_W'(cj);
              out_ch.data.out_value <= dv_sel ? r_store[ad(ci, cj)]
                                             : sat32(q_emit[63:0]);
              out_ch.data.last_of_run <= dv_sel && (3'(ci) + 3'd1 == n)
                                         && (3'(cj) + 3'd1 == n);
              if (3'(cj) + 3'd1 < n) cj <= cj + RW'(1);
              else begin
                cj <= '0;
                if (3'(ci) + 3'd1 < n) ci <= ci + RW'(1);
                else begin
                  ci <= '0;
                  dv_sel <= 1'b1;
                end
              end
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  assign last_beat = out_ch.data.last_of_run;
endmodule

FILE: bench/givens_qr_decomposition_tb.sv
// Self-checking bench for givens_qr_decomposition: loads square matrices and
// checks every Q and R beat against an in-bench fixed-point Givens model.
// Depends on gqr_pkg, gqr_if and the RTL top.
`timescale 1ns / 100ps

module givens_qr_decomposition_tb;
  import gqr_pkg::*;

  localparam longint Q30_ONE   = longint'(1) << 30;
  localparam int     SETTLE    = 1200;
  localparam int     LIMIT     = 2_000_000;
  localparam int     PER_PHASE = 48;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [DIM_W-1:0] cfg_data;

  gqr_in_if  in_bus ();
  gqr_out_if out_bus ();

  givens_qr_decomposition u_top (
    .clk    (clk),
    .rst    (rst),
    .cfg_we (cfg_we),
    .cfg_data (cfg_data),
    .in_ch  (in_bus.sink),
    .out_ch (out_bus.source)
  );

  logic signed [31:0] elem_pending[$];
  result_t            qr_expected[$];
  idle_mode_e         idle_mode;
  int                 hold_left;
  bit                 in_took;
  int                 mismatches;
  int                 cycles;

  // model state
  logic signed [31:0] r_mat[16];
  logic signed [31:0] q_mat[16];
  int                 load_cnt;
  logic [DIM_W-1:0]   dim_reg;

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // round half up, then floor shift
  function automatic longint round_shift(longint v, int sh);
    return (v + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > x) bt = bt >> 2;
    while (bt != 0) begin
      if (x >= res + bt) begin
        x = x - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  function automatic int eff_dim();
    if (dim_reg < 2) return 2;
    if (dim_reg > DEF_MAX_DIM) return DEF_MAX_DIM;
    return int'(dim_reg);
  endfunction

  task automatic givens_rotate(int i, int j, int n);
    longint p, t, nrm, c, s, rj, ri, qj, qi;
    longint unsigned sq;
    p = r_mat[j*4+j];
    t = r_mat[i*4+j];
    if (t == 0) return;
    sq = longint'(p * p) + longint'(t * t);
    nrm = longint'(int_sqrt(sq));
    if (nrm == 0) return;
    c = (p * Q30_ONE) / nrm;
    s = (t * Q30_ONE) / nrm;
    for (int k = 0; k < n; k++) begin
      rj = r_mat[j*4+k];
      ri = r_mat[i*4+k];
      qj = q_mat[j*4+k];
      qi = q_mat[i*4+k];
      r_mat[j*4+k] = clamp32(round_shift(c * rj + s * ri, 30));
      r_mat[i*4+k] = clamp32(round_shift(c * ri - s * rj, 30));
      q_mat[j*4+k] = clamp32(round_shift(c * qj + s * qi, 30));
      q_mat[i*4+k] = clamp32(round_shift(c * qi - s * qj, 30));
    end
  endtask

  task automatic take_elem(logic signed [31:0] v);
    int n;
    result_t res;
    n = eff_dim();
    if (load_cnt >= n * n) load_cnt = 0;
    r_mat[(load_cnt / n)*4 + (load_cnt % n)] = v;
    load_cnt++;
    if (load_cnt < n * n) return;
    load_cnt = 0;
    for (int a = 0; a < 16; a++) q_mat[a] = (a / 4 == a % 4) ? ONE_Q30 : 32'sd0;
    for (int j = 0; j + 1 < n; j++)
      for (int i = j + 1; i < n; i++)
        givens_rotate(i, j, n);
    // Q goes out transposed
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++) begin
        res.which_matrix = 1'b0;
        res.out_row = i[IDX_W-1:0];
        res.out_col = j[IDX_W-1:0];
        res.out_value = clamp32(round_shift(longint'(q_mat[j*4+i]), 14));
        res.last_of_run = 1'b0;
        qr_expected.push_back(res);
      end
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++) begin
        res.which_matrix = 1'b1;
        res.out_row = i[IDX_W-1:0];
        res.out_col = j[IDX_W-1:0];
        res.out_value = r_mat[i*4+j];
        res.last_of_run = (i == n - 1 && j == n - 1);
        qr_expected.push_back(res);
      end
  endtask

  function automatic void check_beat(result_t got);
    result_t want;
    if (qr_expected.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected beat: %p", got);
      return;
    end
    want = qr_expected.pop_front();
    if (got.which_matrix !== want.which_matrix || got.out_row !== want.out_row ||
        got.out_col !== want.out_col || got.out_value !== want.out_value ||
        got.last_of_run !== want.last_of_run) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected m%0d (%0d,%0d) %h last %0d, got m%0d (%0d,%0d) %h last %0d",
                 want.which_matrix, want.out_row, want.out_col, want.out_value,
                 want.last_of_run, got.which_matrix, got.out_row, got.out_col,
                 got.out_value, got.last_of_run);
    end
  endfunction

  // monitor: sample at the rising edge
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("givens_qr_decomposition_tb: errors");
      $finish;
    end else begin
      in_took = 1'b0;
      if (!rst) begin
        if (out_bus.valid && out_bus.ready) check_beat(out_bus.data);
        if (cfg_we) begin
          dim_reg = cfg_data;
          load_cnt = 0;
        end
        if (in_bus.valid && in_bus.ready) begin
          in_took = 1'b1;
          take_elem(in_bus.elem_value);
        end
      end
    end
  end

  // element driver
  always @(negedge clk) begin
    if (rst) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || in_took) begin
      if (elem_pending.size() != 0 &&
          !((idle_mode == IDLE_SEND && $urandom_range(0, 99) < 81) ||
            (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 16))) begin
        in_bus.valid      <= 1'b1;
        in_bus.elem_value <= elem_pending.pop_front();
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // result ready, with an optional long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_bus.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (idle_mode == IDLE_RECV) begin
      out_bus.ready <= ($urandom_range(0, 99) >= 81);
    end else if (idle_mode == IDLE_BOTH) begin
      out_bus.ready <= ($urandom_range(0, 99) >= 16);
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  task automatic write_dim(logic [DIM_W-1:0] v);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    do @(posedge clk);
    while (elem_pending.size() != 0 || in_bus.valid || qr_expected.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_elem();
    case ($urandom_range(0, 9))
      0, 1: return 32'sd0;
      2: case ($urandom_range(0, 3))
           0: return 32'sh7fff_ffff;
           1: return 32'sh8000_0000;
           2: return 32'sd1;
           default: return -32'sd1;
         endcase
      3, 4, 5, 6: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int sizes[8];
    int n, cnt;
    sizes = '{2, 3, 4, 0, 1, 5, 6, 7};
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_bus.valid = 1'b0;
    in_bus.elem_value = '0;
    out_bus.ready = 1'b0;
    idle_mode = IDLE_NONE;
    hold_left = 0;
    mismatches = 0;
    cycles = 0;
    load_cnt = 0;
    dim_reg = 3'd4;
    for (int a = 0; a < 16; a++) r_mat[a] = '0;
    fork
      forever #10 clk = ~clk;
    join_none
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: zero pivot, extremes, zero target, saturation
    elem_pending = '{32'sd0, 32'sh7fff_ffff, 32'sh8000_0000, 32'sd1,
                     32'sh7fff_ffff, 32'sh8000_0000, 32'sd0, -32'sd1,
                     32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000,
                     32'sd0, 32'sd0, 32'sh0001_0000, 32'shffff_ffff};
    drain();
    write_dim(3'd2);
    // identity: every rotation skipped; then a partial load that the write drops
    elem_pending = '{32'sh0001_0000, 32'sd0, 32'sd0, 32'sh0001_0000,
                     32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff};
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      write_dim(sizes[ph][DIM_W-1:0]);
      idle_mode = idle_mode_e'(ph % 4);
      n = (sizes[ph] < 2) ? 2 : (sizes[ph] > 4 ? 4 : sizes[ph]);
      cnt = 0;
      if (ph == 4) hold_left = 1500;
      while (cnt < PER_PHASE) begin
        for (int e = 0; e < n * n; e++) elem_pending.push_back(rand_elem());
        cnt += n * n;
      end
      // leave a partial matrix now and then for the next write to discard
      if (ph % 3 == 1)
        for (int e = 0; e < n; e++) elem_pending.push_back(rand_elem());
      drain();
    end

    if (qr_expected.size() != 0) mismatches++;
    if (mismatches == 0)
      $display("givens_qr_decomposition_tb: clean");
    else
      $display("givens_qr_decomposition_tb: errors");
    $finish;
  end
endmodule
